// ===== src/i2cbw_pkg.sv =====
// shared constants and codes for the i2c byte write / random read master
`default_nettype none
package i2cbw_pkg;

    localparam int unsigned PHASE_W = 16;
    localparam int unsigned WAIT_W  = 24;
    localparam int unsigned CNT_W   = 24;

    // command codes carried in s_tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] CFG_STOP_WAIT   = 2'd1;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd4;
    localparam logic [WAIT_W-1:0]  STOP_WAIT_RST   = 24'd50000;

    // sequencer steps
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SEND  = 3'd2;
    localparam logic [2:0] ST_ACK   = 3'd3;
    localparam logic [2:0] ST_RECV  = 3'd4;
    localparam logic [2:0] ST_STOP  = 3'd5;
    localparam logic [2:0] ST_WAIT  = 3'd6;

    // result word bit positions
    localparam int unsigned RES_SCL  = 0;
    localparam int unsigned RES_PULL = 1;
    localparam int unsigned RES_BUSY = 2;
    localparam int unsigned RES_DONE = 3;

endpackage
`default_nettype wire

// ===== src/i2c_byte_write_random_read_master_unit.sv =====
// i2c master sequencer for one byte write or one random byte read, one bus tick per word
// the result word for an input word is registered when that input word is accepted
// throughput: one word per cycle while the result register can drain; s_tready follows m_tready when it is full
// each word advances the bus sequencer by exactly one tick and returns one result word
// reset (aresetn low, synchronous): sequencer idle, counters and read byte cleared,
// phase_ticks back to 4 and stop_wait_ticks back to 50000
`default_nettype none
module i2c_byte_write_random_read_master_unit
    import i2cbw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // device_byte, mem_address, write_data, sda_in, zero pad
    input  wire logic [1:0]  s_tuser,   // opcode
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // scl_level, sda_pull_low, busy_res, done_res,
                                        // read_data, zero pad
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    logic [PHASE_W-1:0] phase_ticks_reg;
    logic [WAIT_W-1:0]  stop_wait_reg;

    logic [2:0]       step_reg, step_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       bit_reg, bit_next;
    logic [1:0]       byte_reg, byte_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       dev_reg, dev_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       data_reg, data_next;
    logic             rd_reg, rd_next;
    logic [7:0]       rx_reg, rx_next;

    logic             m_valid_reg;
    logic [15:0]      m_data_reg;

    logic             accept;
    logic [1:0]       op;
    logic             sda;
    logic             scl, pull, busy, done;
    logic [7:0]       tx_byte;
    logic [2:0]       tx_pos;
    logic [CNT_W-1:0] len;
    logic             last;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign op  = s_tuser;
    assign sda = s_tdata[24];

    always_comb begin
        step_next  = step_reg;
        count_next = count_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        dev_next   = dev_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        rd_next    = rd_reg;
        rx_next    = rx_reg;
        scl        = 1'b0;
        pull       = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        tx_byte    = 8'd0;
        tx_pos     = 3'd0;
        len        = '0;
        last       = 1'b0;

        // an idle command tick is already the first tick of the start
        if (step_reg == ST_IDLE || step_reg > ST_WAIT) begin
            step_next = ST_IDLE;
            if (op == OP_WRITE || op == OP_READ) begin
                dev_next   = s_tdata[7:0];
                addr_next  = s_tdata[15:8];
                data_next  = s_tdata[23:16];
                rd_next    = (op == OP_READ);
                step_next  = ST_START;
                bit_next   = 4'd0;
                byte_next  = 2'd0;
                count_next = '0;
                shift_next = 8'd0;
            end
        end

        if (step_next != ST_IDLE) begin
            busy = 1'b1;

            if (byte_next == 2'd0) begin
                tx_byte = dev_next;
            end else if (byte_next == 2'd1) begin
                tx_byte = addr_next;
            end else if (rd_next) begin
                tx_byte = dev_next + 8'd1;
            end else begin
                tx_byte = data_next;
            end
            tx_pos = 3'd7 - bit_next[3:1];

            unique case (step_next) inside
                ST_START: begin
                    scl  = (bit_next == 4'd1 || bit_next == 4'd2);
                    pull = (bit_next >= 4'd2);
                end
                ST_SEND: begin
                    scl  = bit_next[0];
                    pull = !tx_byte[tx_pos];
                end
                ST_ACK, ST_RECV: begin
                    scl  = bit_next[0];
                    pull = 1'b0;
                end
                ST_STOP: begin
                    scl  = (bit_next >= 4'd1);
                    pull = (bit_next <= 4'd1);
                end
                default: begin
                    scl  = 1'b0;
                    pull = 1'b0;
                end
            endcase

            len = (step_next == ST_WAIT) ? stop_wait_reg
                                         : {{(CNT_W-PHASE_W){1'b0}}, phase_ticks_reg};
            if (len == '0) begin
                len = {{(CNT_W-1){1'b0}}, 1'b1};
            end
            last = ({1'b0, count_next} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, len};

            if (!last) begin
                count_next = count_next + {{(CNT_W-1){1'b0}}, 1'b1};
            end else begin
                count_next = '0;
                unique case (step_next)
                    ST_START: begin
                        if (bit_next < 4'd3) begin
                            bit_next = bit_next + 4'd1;
                        end else begin
                            step_next = ST_SEND;
                            bit_next  = 4'd0;
                        end
                    end
                    ST_SEND: begin
                        if (bit_next < 4'd15) begin
                            bit_next = bit_next + 4'd1;
                        end else begin
                            step_next = ST_ACK;
                            bit_next  = 4'd0;
                        end
                    end
                    ST_ACK: begin
                        if (bit_next < 4'd1) begin
                            bit_next = bit_next + 4'd1;
                        end else begin
                            bit_next = 4'd0;
                            if (byte_next == 2'd0) begin
                                byte_next = 2'd1;
                                step_next = ST_SEND;
                            end else if (byte_next == 2'd1) begin
                                byte_next = 2'd2;
                                // read goes through a repeated start
                                step_next = rd_next ? ST_START : ST_SEND;
                            end else if (byte_next == 2'd2 && rd_next) begin
                                byte_next  = 2'd3;
                                shift_next = 8'd0;
                                step_next  = ST_RECV;
                            end else begin
                                step_next = ST_STOP;
                            end
                        end
                    end
                    ST_RECV: begin
                        // sample at the end of the scl low phase
                        if (!bit_next[0]) begin
                            shift_next = {shift_next[6:0], sda};
                        end
                        if (bit_next < 4'd15) begin
                            bit_next = bit_next + 4'd1;
                        end else begin
                            rx_next   = shift_next;
                            step_next = ST_ACK;
                            bit_next  = 4'd0;
                        end
                    end
                    ST_STOP: begin
                        if (bit_next < 4'd2) begin
                            bit_next = bit_next + 4'd1;
                        end else begin
                            step_next = ST_WAIT;
                            bit_next  = 4'd0;
                        end
                    end
                    default: begin
                        done      = 1'b1;
                        step_next = ST_IDLE;
                        bit_next  = 4'd0;
                        byte_next = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            stop_wait_reg   <= STOP_WAIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_PHASE_TICKS) begin
                phase_ticks_reg <= cfg_data[PHASE_W-1:0];
            end else if (cfg_index == CFG_STOP_WAIT) begin
                stop_wait_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= ST_IDLE;
            count_reg <= '0;
            bit_reg   <= 4'd0;
            byte_reg  <= 2'd0;
            shift_reg <= 8'd0;
            dev_reg   <= 8'd0;
            addr_reg  <= 8'd0;
            data_reg  <= 8'd0;
            rd_reg    <= 1'b0;
            rx_reg    <= 8'd0;
        end else if (accept) begin
            step_reg  <= step_next;
            count_reg <= count_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            dev_reg   <= dev_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            rd_reg    <= rd_next;
            rx_reg    <= rx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {4'd0, rx_next, done, busy, pull, scl};
        end
    end

endmodule
`default_nettype wire

// ===== src/i2cbw_checker.sv =====
// port-level checks for the i2c byte write / random read master
`default_nettype none
module i2cbw_checker
    import i2cbw_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // result register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // done only ever comes on a busy tick
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RES_DONE] |-> m_tdata[RES_BUSY])
        else $error("done without busy");

    // idle ticks keep scl low and sda released
    a_idle_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[RES_BUSY] |-> !m_tdata[RES_SCL] && !m_tdata[RES_PULL])
        else $error("pins active while idle");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // input side is never blocked while the result register is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind i2c_byte_write_random_read_master_unit i2cbw_checker u_i2cbw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
